>>> design/ldf_pkg.sv
// Shared types, constants and the CRC-32 byte step for the log record deframer.
// No dependencies; ldf_front, ldf_back and the top module import this package.
package ldf_pkg;

   localparam int HEADER_LEN  = 24;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [4:0]  HDR_LAST      = 5'(HEADER_LEN - 1);
   localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
   localparam logic [47:0] TAIL_MAX      = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] TALLY_MAX     = 32'hFFFF_FFFF;
   localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;
   localparam logic [31:0] MAX_CNT_RESET = 32'd65536;
   localparam logic [31:0] VERSION_ONE   = 32'd1;

   // Header byte offsets
   localparam logic [4:0] HDR_VERSION = 5'd4;
   localparam logic [4:0] HDR_LEN_LO  = 5'd8;
   localparam logic [4:0] HDR_LEN_HI  = 5'd12;
   localparam logic [4:0] HDR_CHECK   = 5'd16;
   localparam logic [4:0] HDR_RSVD    = 5'd20;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   localparam logic [1:0] CSR_MAX_LEN = 2'd0;
   localparam logic [1:0] CSR_MAX_CNT = 2'd1;

   localparam logic [2:0] ST_CLEAN       = 3'd0;
   localparam logic [2:0] ST_CUT_HEADER  = 3'd1;
   localparam logic [2:0] ST_CUT_PAYLOAD = 3'd2;
   localparam logic [2:0] ST_MAGIC       = 3'd3;
   localparam logic [2:0] ST_VERSION     = 3'd4;
   localparam logic [2:0] ST_LENGTH      = 3'd5;
   localparam logic [2:0] ST_CRC         = 3'd6;
   localparam logic [2:0] ST_TOO_MANY    = 3'd7;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_STOPPED = 3'b100
   } phase_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
   } item_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] m;
      unique case (idx)
         2'd0:    m = 8'h46;
         2'd1:    m = 8'h58;
         2'd2:    m = 8'h52;
         default: m = 8'h31;
      endcase
      return m;
   endfunction

   // Reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> design/ldf_if.sv
// Request and response channel interfaces of the log record deframer.
// Standalone; valid/ready handshake with source and sink modports.
interface ldf_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] data_byte;

   modport source (output valid, output cmd, output data_byte, input ready);
   modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface ldf_rsp_if;
   logic        valid;
   logic        ready;
   logic        has_byte;
   logic [7:0]  payload_byte;
   logic        record_end;
   logic        record_ok;
   logic        stream_done;
   logic [2:0]  status;
   logic [31:0] good_records;
   logic [47:0] tail_bytes;

   modport source (output valid, output has_byte, output payload_byte, output record_end,
                   output record_ok, output stream_done, output status,
                   output good_records, output tail_bytes, input ready);
   modport sink   (input valid, input has_byte, input payload_byte, input record_end,
                   input record_ok, input stream_done, input status,
                   input good_records, input tail_bytes, output ready);
endinterface

>>> design/ldf_front.sv
// Front end: accepts requests and holds them in a short queue for the parser.
// Depends on ldf_pkg and ldf_req_if.
module ldf_front
   import ldf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ldf_req_if.sink   req_chan,
   output logic      q_valid,
   output item_type  q_item,
   input  logic      q_pop
);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              push;
   logic              pop;

   assign req_chan.ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push    = req_chan.valid && req_chan.ready;
   assign q_valid = (count_ff != '0);
   assign pop     = q_pop && q_valid;
   assign q_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{cmd: req_chan.cmd, data_byte: req_chan.data_byte};
      end
   end

endmodule

>>> design/ldf_back.sv
// Back end: header parse, CRC check, counters and the response register.
// Depends on ldf_pkg and ldf_rsp_if; fed by the queue in ldf_front.
module ldf_back
   import ldf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   ldf_rsp_if.source   rsp_chan
);

   typedef struct packed {
      logic        has_byte;
      logic [7:0]  payload_byte;
      logic        record_end;
      logic        record_ok;
      logic        stream_done;
      logic [2:0]  status;
      logic [31:0] good_records;
      logic [47:0] tail_bytes;
   } rsp_type;

   logic [31:0] max_len_ff, max_cnt_ff;

   phase_type   phase_ff, phase_in;
   logic [4:0]  pos_ff, pos_in;
   logic        magic_ff, magic_in;
   logic [31:0] version_ff, version_in;
   logic [31:0] len_lo_ff, len_lo_in;
   logic        len_hi_nz_ff, len_hi_nz_in;
   logic [31:0] check_ff, check_in;
   logic [31:0] remain_ff, remain_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] tally_ff, tally_in;
   logic [47:0] since_ff, since_in;
   logic [2:0]  fault_ff, fault_in;

   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;

   logic        fire;
   logic        emit;
   rsp_type     res;
   logic [7:0]  b;
   logic [31:0] crc_next;
   logic [47:0] since_inc;
   logic [31:0] tally_inc;

   assign q_pop = !out_valid_ff || rsp_chan.ready;
   assign fire  = q_valid && q_pop;
   assign b     = q_item.data_byte;

   assign crc_next  = crc_byte(crc_ff, b);
   assign since_inc = (since_ff != TAIL_MAX) ? since_ff + 48'd1 : since_ff;
   assign tally_inc = (tally_ff != TALLY_MAX) ? tally_ff + 32'd1 : tally_ff;

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      magic_in     = magic_ff;
      version_in   = version_ff;
      len_lo_in    = len_lo_ff;
      len_hi_nz_in = len_hi_nz_ff;
      check_in     = check_ff;
      remain_in    = remain_ff;
      crc_in       = crc_ff;
      tally_in     = tally_ff;
      since_in     = since_ff;
      fault_in     = fault_ff;
      emit         = 1'b0;
      res          = '0;

      if (q_item.cmd == CMD_END) begin
         emit            = 1'b1;
         res.stream_done = 1'b1;
         res.good_records = tally_ff;
         unique case (phase_ff)
            PH_STOPPED: begin
               res.status     = fault_ff;
               res.tail_bytes = since_ff;
            end
            PH_PAYLOAD: begin
               res.status     = ST_CUT_PAYLOAD;
               res.tail_bytes = since_ff;
               res.record_end = 1'b1;
            end
            default: begin
               if (pos_ff != 5'd0) begin
                  res.status     = ST_CUT_HEADER;
                  res.tail_bytes = since_ff;
               end
            end
         endcase
         // back to a fresh stream, limits kept
         phase_in     = PH_HEADER;
         pos_in       = '0;
         magic_in     = 1'b1;
         version_in   = '0;
         len_lo_in    = '0;
         len_hi_nz_in = 1'b0;
         check_in     = '0;
         remain_in    = '0;
         crc_in       = CRC_INIT;
         tally_in     = '0;
         since_in     = '0;
         fault_in     = ST_CLEAN;
      end else begin
         unique case (phase_ff)
            PH_STOPPED: begin
               since_in = since_inc;
            end
            PH_PAYLOAD: begin
               since_in         = since_inc;
               crc_in           = crc_next;
               remain_in        = remain_ff - 32'd1;
               emit             = 1'b1;
               res.has_byte     = 1'b1;
               res.payload_byte = b;
               if (remain_ff == 32'd1) begin
                  res.record_end = 1'b1;
                  if (~crc_next == check_ff) begin
                     res.record_ok = 1'b1;
                     tally_in      = tally_inc;
                     phase_in      = PH_HEADER;
                     pos_in        = '0;
                     magic_in      = 1'b1;
                     since_in      = '0;
                  end else begin
                     phase_in = PH_STOPPED;
                     fault_in = ST_CRC;
                  end
               end
            end
            default: begin
               if (pos_ff == 5'd0) begin
                  // first header byte: clear the fields being gathered
                  since_in     = 48'd1;
                  magic_in     = 1'b1;
                  version_in   = '0;
                  len_lo_in    = '0;
                  len_hi_nz_in = 1'b0;
                  check_in     = '0;
               end else begin
                  since_in = since_inc;
               end
               if (pos_ff == 5'd0 && tally_ff >= max_cnt_ff) begin
                  phase_in = PH_STOPPED;
                  fault_in = ST_TOO_MANY;
               end else begin
                  if (pos_ff < HDR_VERSION) begin
                     if (b != magic_byte(pos_ff[1:0])) begin
                        magic_in = 1'b0;
                     end
                  end else if (pos_ff < HDR_LEN_LO) begin
                     version_in[8*pos_ff[1:0] +: 8] = b;
                  end else if (pos_ff < HDR_LEN_HI) begin
                     len_lo_in[8*pos_ff[1:0] +: 8] = b;
                  end else if (pos_ff < HDR_CHECK) begin
                     if (b != 8'd0) begin
                        len_hi_nz_in = 1'b1;
                     end
                  end else if (pos_ff < HDR_RSVD) begin
                     check_in[8*pos_ff[1:0] +: 8] = b;
                  end
                  pos_in = pos_ff + 5'd1;
                  if (pos_ff == HDR_LAST) begin
                     pos_in = '0;
                     if (!magic_in) begin
                        phase_in = PH_STOPPED;
                        fault_in = ST_MAGIC;
                     end else if (version_in != VERSION_ONE) begin
                        phase_in = PH_STOPPED;
                        fault_in = ST_VERSION;
                     end else if (len_hi_nz_in || len_lo_in > max_len_ff) begin
                        phase_in = PH_STOPPED;
                        fault_in = ST_LENGTH;
                     end else begin
                        crc_in = CRC_INIT;
                        if (len_lo_in == 32'd0) begin
                           // empty payload: verdict rides on the last header byte
                           emit           = 1'b1;
                           res.record_end = 1'b1;
                           if (check_in == 32'd0) begin
                              res.record_ok = 1'b1;
                              tally_in      = tally_inc;
                              magic_in      = 1'b1;
                              since_in      = '0;
                           end else begin
                              phase_in = PH_STOPPED;
                              fault_in = ST_CRC;
                           end
                        end else begin
                           remain_in = len_lo_in;
                           phase_in  = PH_PAYLOAD;
                        end
                     end
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (fire && emit) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MAX_LEN_RESET;
         max_cnt_ff   <= MAX_CNT_RESET;
         phase_ff     <= PH_HEADER;
         pos_ff       <= '0;
         magic_ff     <= 1'b1;
         version_ff   <= '0;
         len_lo_ff    <= '0;
         len_hi_nz_ff <= 1'b0;
         check_ff     <= '0;
         remain_ff    <= '0;
         crc_ff       <= CRC_INIT;
         tally_ff     <= '0;
         since_ff     <= '0;
         fault_ff     <= ST_CLEAN;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en && csr_index == CSR_MAX_LEN) begin
            max_len_ff <= csr_wdata;
         end
         if (csr_wr_en && csr_index == CSR_MAX_CNT) begin
            max_cnt_ff <= csr_wdata;
         end
         if (fire) begin
            phase_ff     <= phase_in;
            pos_ff       <= pos_in;
            magic_ff     <= magic_in;
            version_ff   <= version_in;
            len_lo_ff    <= len_lo_in;
            len_hi_nz_ff <= len_hi_nz_in;
            check_ff     <= check_in;
            remain_ff    <= remain_in;
            crc_ff       <= crc_in;
            tally_ff     <= tally_in;
            since_ff     <= since_in;
            fault_ff     <= fault_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.has_byte     = out_ff.has_byte;
   assign rsp_chan.payload_byte = out_ff.payload_byte;
   assign rsp_chan.record_end   = out_ff.record_end;
   assign rsp_chan.record_ok    = out_ff.record_ok;
   assign rsp_chan.stream_done  = out_ff.stream_done;
   assign rsp_chan.status       = out_ff.status;
   assign rsp_chan.good_records = out_ff.good_records;
   assign rsp_chan.tail_bytes   = out_ff.tail_bytes;

endmodule

>>> design/log_record_deframer_top.sv
// Log record deframer: one log byte or end marker per request, at most one response each.
// Requests are registered in the ldf_front queue, then in the ldf_back response register.
// One request per cycle unless a response stalls; parse and CRC step are combinational.
// A four-entry request queue lets the front keep accepting while a response is stalled.
// Synchronous active-high reset clears the parser, the queue and sets default limits.
// Depends on ldf_pkg, ldf_if, ldf_front and ldf_back.
module log_record_deframer_top
   import ldf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ldf_req_if.sink     req_chan,
   ldf_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   ldf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   ldf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> sim/tb.sv
// Self-checking bench for log_record_deframer_top: framed byte streams in, checked responses out.
// Depends on ldf_pkg, ldf_if and the deframer RTL; a small tracker class predicts each response.
`timescale 1ns / 100ps

module tb;
   import ldf_pkg::*;

   localparam logic [31:0] FRAME_MAGIC = 32'h4658_5231;   // "FXR1", first byte in the top lane
   localparam int          STALL_LIMIT = 1000;
   localparam int          RANDOM_ITEMS = 2000;
   localparam int          QUIET_TAIL   = 300;
   localparam int          SETTLE_CYCLES = 8;

   typedef enum {
      FRAME_GOOD,
      FRAME_BAD_MAGIC,
      FRAME_BAD_VERSION,
      FRAME_TOO_LONG,
      FRAME_BAD_CRC
   } frame_kind_type;

   typedef struct packed {
      logic        has_byte;
      logic [7:0]  payload_byte;
      logic        record_end;
      logic        record_ok;
      logic        stream_done;
      logic [2:0]  status;
      logic [31:0] good_records;
      logic [47:0] tail_bytes;
   } deframer_result_type;

   // Tracks the parser state of the block and holds the responses still owed.
   class frame_tracker_type;
      logic [31:0]         len_limit;
      logic [31:0]         count_limit;
      phase_type           stage;
      logic [4:0]          hdr_index;
      logic                magic_ok;
      logic [31:0]         version_field;
      logic [63:0]         length_field;
      logic [31:0]         crc_field;
      logic [63:0]         bytes_left;
      logic [31:0]         crc_acc;
      logic [31:0]         tally;
      logic [47:0]         since_start;
      logic [2:0]          stop_code;
      deframer_result_type awaited[$];
      int unsigned         errors;

      function new();
         len_limit   = MAX_LEN_RESET;
         count_limit = MAX_CNT_RESET;
         errors      = 0;
         restart();
      endfunction

      static function logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
         logic [31:0] r;
         r = c ^ {24'd0, b};
         for (int k = 0; k < 8; k++)
            r = r[0] ? ((r >> 1) ^ 32'hEDB8_8320) : (r >> 1);
         return r;
      endfunction

      function void restart();
         stage         = PH_HEADER;
         hdr_index     = '0;
         magic_ok      = 1'b1;
         version_field = '0;
         length_field  = '0;
         crc_field     = '0;
         bytes_left    = '0;
         crc_acc       = '1;
         tally         = '0;
         since_start   = '0;
         stop_code     = ST_CLEAN;
      endfunction

      function void count_byte();
         if (since_start != '1)
            since_start++;
      endfunction

      function void halt(logic [2:0] code);
         stage     = PH_STOPPED;
         stop_code = code;
      endfunction

      function void pass_record();
         if (tally != '1)
            tally++;
         stage       = PH_HEADER;
         hdr_index   = '0;
         magic_ok    = 1'b1;
         since_start = '0;
      endfunction

      function bit live();
         return stage != PH_STOPPED;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void owe(deframer_result_type r);
         awaited = {awaited, r};
      endfunction

      function void note_request(logic cmd, logic [7:0] b);
         deframer_result_type r;
         int                  p;
         r = '0;
         if (cmd == CMD_END) begin
            r.stream_done  = 1'b1;
            r.good_records = tally;
            if (stage == PH_STOPPED) begin
               r.status     = stop_code;
               r.tail_bytes = since_start;
            end else if (stage == PH_PAYLOAD) begin
               r.status     = ST_CUT_PAYLOAD;
               r.tail_bytes = since_start;
               r.record_end = 1'b1;
            end else if (hdr_index != 0) begin
               r.status     = ST_CUT_HEADER;
               r.tail_bytes = since_start;
            end
            owe(r);
            restart();
            return;
         end
         if (stage == PH_STOPPED) begin
            count_byte();
            return;
         end
         if (stage == PH_HEADER) begin
            p = hdr_index;
            if (p == 0) begin
               since_start = '0;
               // a further record past the count limit stops the stream here
               if (tally >= count_limit) begin
                  count_byte();
                  halt(ST_TOO_MANY);
                  return;
               end
               magic_ok      = 1'b1;
               version_field = '0;
               length_field  = '0;
               crc_field     = '0;
            end
            count_byte();
            if (p < 4) begin
               if (b != FRAME_MAGIC[8*(3-p) +: 8])
                  magic_ok = 1'b0;
            end else if (p < 8) begin
               version_field[8*(p-4) +: 8] = b;
            end else if (p < 16) begin
               length_field[8*(p-8) +: 8] = b;
            end else if (p < 20) begin
               crc_field[8*(p-16) +: 8] = b;
            end
            hdr_index = 5'(p + 1);
            if (hdr_index < HEADER_LEN)
               return;
            hdr_index = '0;
            if (!magic_ok) begin
               halt(ST_MAGIC);
               return;
            end
            if (version_field != 32'd1) begin
               halt(ST_VERSION);
               return;
            end
            if (length_field > {32'd0, len_limit}) begin
               halt(ST_LENGTH);
               return;
            end
            crc_acc = '1;
            if (length_field == 0) begin
               // empty payload: verdict rides on the last header byte
               r.record_end = 1'b1;
               if (crc_field == 0) begin
                  r.record_ok = 1'b1;
                  pass_record();
               end else begin
                  halt(ST_CRC);
               end
               owe(r);
               return;
            end
            bytes_left = length_field;
            stage      = PH_PAYLOAD;
            return;
         end
         count_byte();
         crc_acc        = crc_update(crc_acc, b);
         r.has_byte     = 1'b1;
         r.payload_byte = b;
         if (bytes_left != 0)
            bytes_left--;
         if (bytes_left == 0) begin
            r.record_end = 1'b1;
            if (~crc_acc == crc_field) begin
               r.record_ok = 1'b1;
               pass_record();
            end else begin
               halt(ST_CRC);
            end
         end
         owe(r);
      endfunction

      function void compare_field(string name, logic [47:0] want, logic [47:0] seen);
         if (seen !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, seen);
         end
      endfunction

      function void check_response(deframer_result_type seen);
         deframer_result_type want;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: response with none expected, expected none, got 0x%0h", $time, seen);
            return;
         end
         want = awaited.pop_front();
         compare_field("has_byte", want.has_byte, seen.has_byte);
         compare_field("payload_byte", want.payload_byte, seen.payload_byte);
         compare_field("record_end", want.record_end, seen.record_end);
         compare_field("record_ok", want.record_ok, seen.record_ok);
         compare_field("stream_done", want.stream_done, seen.stream_done);
         compare_field("status", want.status, seen.status);
         compare_field("good_records", want.good_records, seen.good_records);
         compare_field("tail_bytes", want.tail_bytes, seen.tail_bytes);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   ldf_req_if req_chan ();
   ldf_rsp_if rsp_chan ();

   log_record_deframer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   frame_tracker_type   tracker;
   bit                  idle_on;
   int unsigned         items_counted;
   logic [31:0]         cur_len_limit;
   int                  stall_left;
   int                  quiet_cycles;
   deframer_result_type rsp_seen;

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // response side: random stall bursts, none once idling is switched off
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (!reset && idle_on && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(1, 15) - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            tracker.note_request(req_chan.cmd, req_chan.data_byte);
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_seen = {rsp_chan.has_byte, rsp_chan.payload_byte, rsp_chan.record_end,
                        rsp_chan.record_ok, rsp_chan.stream_done, rsp_chan.status,
                        rsp_chan.good_records, rsp_chan.tail_bytes};
            tracker.check_response(rsp_seen);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("log_record_deframer_top verification failed");
         $finish;
      end
   end

   // Leaves valid high on return so that back-to-back requests need no second assignment.
   task automatic send_request(logic cmd, logic [7:0] b);
      int unsigned gap;
      if (tracker.live() || cmd == CMD_END)
         items_counted++;
      if (idle_on && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 15);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.cmd       <= cmd;
      req_chan.data_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_end();
      send_request(CMD_END, 8'($urandom));
   endtask

   // Sends one record; cut >= 0 truncates it to that many bytes.
   task automatic send_frame(int unsigned len, frame_kind_type kind, int cut);
      logic [7:0]  frame[$];
      logic [7:0]  body[$];
      logic [31:0] magic;
      logic [31:0] ver;
      logic [63:0] dlen;
      logic [31:0] chk;
      logic [31:0] rsvd;
      int          lane;
      int          total;
      magic = FRAME_MAGIC;
      ver   = 32'd1;
      dlen  = 64'(len);
      chk   = '1;
      rsvd  = $urandom;
      for (int i = 0; i < len; i++) begin
         body = {body, 8'($urandom)};
         chk = frame_tracker_type::crc_update(chk, body[i]);
      end
      chk = ~chk;
      case (kind)
         FRAME_BAD_MAGIC: begin
            lane = $urandom_range(0, 3);
            magic[8*lane +: 8] = magic[8*lane +: 8] ^ 8'($urandom_range(1, 255));
         end
         FRAME_BAD_VERSION: begin
            ver = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom);
            if (ver == 32'd1)
               ver = 32'd2;
         end
         FRAME_TOO_LONG: begin
            if ($urandom_range(0, 1) == 0)
               dlen = 64'(cur_len_limit) + 64'd1;
            else
               dlen = {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
         end
         FRAME_BAD_CRC: chk = chk ^ 32'($urandom_range(1, 32'hFFFF_FFFF));
         default: ;
      endcase
      for (int p = 0; p < 4; p++) frame = {frame, magic[8*(3-p) +: 8]};
      for (int p = 0; p < 4; p++) frame = {frame, ver[8*p +: 8]};
      for (int p = 0; p < 8; p++) frame = {frame, dlen[8*p +: 8]};
      for (int p = 0; p < 4; p++) frame = {frame, chk[8*p +: 8]};
      for (int p = 0; p < 4; p++) frame = {frame, rsvd[8*p +: 8]};
      frame = {frame, body};
      total = (cut >= 0 && cut < frame.size()) ? cut : frame.size();
      for (int i = 0; i < total; i++)
         send_request(CMD_BYTE, frame[i]);
   endtask

   function automatic int unsigned pick_length();
      int unsigned n;
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 80) : $urandom_range(0, 16);
      if (n > cur_len_limit)
         n = cur_len_limit;
      return n;
   endfunction

   // Drop valid and wait for every owed response, then let the pipeline empty.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(logic [31:0] len_max, logic [31:0] cnt_max);
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MAX_LEN;
      csr_wdata <= len_max;
      @(negedge clock);
      csr_index <= CSR_MAX_CNT;
      csr_wdata <= cnt_max;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      tracker.len_limit   = len_max;
      tracker.count_limit = cnt_max;
      cur_len_limit       = len_max;
   endtask

   // Mostly well-formed records, with faults, truncation and noise mixed in.
   task automatic run_stream(int unsigned budget);
      int unsigned start;
      int unsigned pick;
      int unsigned len;
      bit          cut_off;
      start   = items_counted;
      cut_off = 1'b0;
      while (!cut_off && tracker.live() && items_counted - start < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_frame(pick_length(), FRAME_GOOD, -1);
         end else if (pick < 85) begin
            case (pick % 4)
               0:       send_frame(pick_length(), FRAME_BAD_MAGIC, -1);
               1:       send_frame(pick_length(), FRAME_BAD_VERSION, -1);
               2:       send_frame(pick_length(), FRAME_TOO_LONG, -1);
               default: send_frame(pick_length(), FRAME_BAD_CRC, -1);
            endcase
         end else if (pick < 93) begin
            len = pick_length();
            send_frame(len, FRAME_GOOD, $urandom_range(1, 23 + len));
            cut_off = 1'b1;
         end else begin
            repeat ($urandom_range(1, 12)) send_request(CMD_BYTE, 8'($urandom));
         end
      end
      // trailing bytes after a fault only lengthen the tail
      if (!tracker.live() && $urandom_range(0, 1) == 1)
         repeat ($urandom_range(1, 20)) send_request(CMD_BYTE, 8'($urandom));
      send_end();
   endtask

   initial begin
      logic [31:0] len_set[7];
      logic [31:0] cnt_set[7];
      int unsigned random_start;
      int unsigned phase_start;
      int          sel;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_MAX_LEN;
      csr_wdata          = '0;
      req_chan.valid     = 1'b0;
      req_chan.cmd       = CMD_BYTE;
      req_chan.data_byte = '0;
      rsp_chan.ready     = 1'b0;
      stall_left         = 0;
      quiet_cycles       = 0;
      idle_on            = 1'b1;
      items_counted      = 0;
      cur_len_limit      = MAX_LEN_RESET;
      tracker            = new();
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: clean streams, every fault, truncation and the limits
      send_end();
      send_frame(0, FRAME_GOOD, -1);
      send_frame(3, FRAME_GOOD, -1);
      send_end();
      send_frame(0, FRAME_BAD_CRC, -1);
      send_request(CMD_BYTE, 8'hFF);
      send_end();
      send_frame(5, FRAME_GOOD, 10);
      send_end();
      send_frame(6, FRAME_GOOD, 27);
      send_end();
      send_frame(4, FRAME_BAD_CRC, -1);
      send_end();
      send_frame(2, FRAME_BAD_MAGIC, -1);
      send_end();
      send_frame(2, FRAME_BAD_VERSION, -1);
      send_end();
      send_frame(2, FRAME_TOO_LONG, -1);
      send_end();
      configure(32'd5, 32'd1);
      send_frame(5, FRAME_GOOD, -1);
      send_end();
      send_frame(5, FRAME_GOOD, -1);
      send_frame(1, FRAME_GOOD, -1);
      send_end();
      configure(32'd0, 32'hFFFF_FFFF);
      send_frame(0, FRAME_GOOD, -1);
      send_frame(0, FRAME_TOO_LONG, -1);
      send_end();
      configure(32'hFFFF_FFFF, MAX_CNT_RESET);
      send_frame(8, FRAME_GOOD, -1);
      send_frame(2, FRAME_TOO_LONG, -1);
      send_end();

      len_set = '{MAX_LEN_RESET, 32'hFFFF_FFFF, 32'd0, 32'd24, 32'd7, 32'd64, 32'd0};
      cnt_set = '{MAX_CNT_RESET, 32'hFFFF_FFFF, 32'd4, 32'd2, 32'hFFFF_FFFF, 32'd1, 32'd1};
      random_start = items_counted;
      sel = 0;
      while (items_counted - random_start < RANDOM_ITEMS) begin
         if (sel == 6)
            configure($urandom_range(0, 40), $urandom_range(1, 8));
         else
            configure(len_set[sel], cnt_set[sel]);
         sel = (sel + 1) % 7;
         phase_start = items_counted;
         while (items_counted - phase_start < 250 &&
                items_counted - random_start < RANDOM_ITEMS) begin
            idle_on = (items_counted - random_start < RANDOM_ITEMS - QUIET_TAIL);
            run_stream($urandom_range(20, 200));
         end
      end

      settle();
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("log_record_deframer_top verification clean");
      else
         $display("log_record_deframer_top verification failed");
      $finish;
   end

endmodule

>>> files.f
design/ldf_pkg.sv
design/ldf_if.sv
design/ldf_front.sv
design/ldf_back.sv
design/log_record_deframer_top.sv
sim/tb.sv
